// ----- src/gcd_pkg.sv -----
`timescale 1ns / 1ps

package gcd_pkg;

  localparam int OpW  = 64;
  localparam int ResW = 63;
  localparam int CntW = 6;

  localparam logic [CntW-1:0] LastStep = CntW'(OpW - 1);
  localparam logic [ResW-1:0] MaxPos   = {ResW{1'b1}};
  localparam logic [OpW-1:0]  SignBit  = {1'b1, {(OpW-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic start_rdiv;
    logic start_qdiv;
    logic div_step;
    logic rdiv_done;
    logic qdiv_done;
    logic mul_step;
    logic res_zero;
    logic res_gcd;
    logic res_lcm;
    logic out_load;
  } gcd_cmd_t;

  typedef struct packed {
    logic mode;
    logic zero_op;
    logic b_zero;
    logic dvs_zero;
  } gcd_sts_t;

endpackage

// ----- src/gcd_req_if.sv -----
`timescale 1ns / 1ps

interface gcd_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] left_operand;
  logic [63:0] right_operand;

  modport source(output valid, output mode, output left_operand, output right_operand,
                 input ready);
  modport sink(input valid, input mode, input left_operand, input right_operand,
               output ready);
endinterface

// ----- src/gcd_rsp_if.sv -----
`timescale 1ns / 1ps

interface gcd_rsp_if;
  logic        valid;
  logic        ready;
  logic [62:0] result;

  modport source(output valid, output result, input ready);
  modport sink(input valid, input result, output ready);
endinterface

// ----- src/gcd_dp.sv -----
`timescale 1ns / 1ps

module gcd_dp import gcd_pkg::*; (
  input  logic            clk,
  input  logic            mode_in,
  input  logic [OpW-1:0]  left_in,
  input  logic [OpW-1:0]  right_in,
  input  gcd_cmd_t        cmd,
  output gcd_sts_t        sts,
  output logic [ResW-1:0] result
);

  logic            mode_r;
  logic            lneg;
  logic [OpW-1:0]  lmag;
  logic [OpW-1:0]  right_r;
  logic [OpW-1:0]  a;
  logic [OpW-1:0]  b;
  logic [OpW-1:0]  dvs;
  logic [OpW-1:0]  rem;
  logic [OpW-1:0]  quo;
  logic [ResW-1:0] res;
  logic [ResW-1:0] out_result;

  logic [OpW-1:0]  left_mag;
  logic [OpW-1:0]  right_mag;
  logic [OpW:0]    trial;
  logic [OpW:0]    diff;
  logic            fits;
  logic [OpW-1:0]  rem_step;
  logic [OpW-1:0]  acc_sum;
  logic [OpW-1:0]  lcm_mag;

  assign left_mag  = left_in[OpW-1] ? (~left_in + 1'b1) : left_in;
  assign right_mag = right_in[OpW-1] ? (~right_in + 1'b1) : right_in;

  // One restoring division step: shift the next dividend bit into the remainder.
  assign trial    = {rem, quo[OpW-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = trial >= {1'b0, dvs};
  assign rem_step = fits ? diff[OpW-1:0] : trial[OpW-1:0];

  assign acc_sum = rem + (b[0] ? quo : '0);
  assign lcm_mag = rem[OpW-1] ? (~rem + 1'b1) : rem;

  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      mode_r  <= mode_in;
      lneg    <= left_in[OpW-1];
      lmag    <= left_mag;
      right_r <= right_in;
      a       <= left_mag;
      b       <= right_mag;
    end else if (cmd.start_rdiv) begin
      rem <= '0;
      quo <= a;
      dvs <= b;
    end else if (cmd.start_qdiv) begin
      rem <= '0;
      quo <= lmag;
      dvs <= a;
    end else if (cmd.div_step) begin
      rem <= rem_step;
      quo <= {quo[OpW-2:0], fits};
    end else if (cmd.rdiv_done) begin
      a <= dvs;
      b <= rem;
    end else if (cmd.qdiv_done) begin
      quo <= lneg ? (~quo + 1'b1) : quo;
      rem <= '0;
      b   <= right_r;
    end else if (cmd.mul_step) begin
      rem <= acc_sum;
      quo <= {quo[OpW-2:0], 1'b0};
      b   <= {1'b0, b[OpW-1:1]};
    end else if (cmd.res_zero) begin
      res <= '0;
    end else if (cmd.res_gcd) begin
      res <= a[OpW-1] ? MaxPos : a[ResW-1:0];
    end else if (cmd.res_lcm) begin
      res <= (rem == SignBit) ? MaxPos : lcm_mag[ResW-1:0];
    end else if (cmd.out_load) begin
      out_result <= res;
    end else begin
    end
  end

  assign sts.mode     = mode_r;
  assign sts.zero_op  = (lmag == '0) || (right_r == '0);
  assign sts.b_zero   = (b == '0);
  assign sts.dvs_zero = (dvs == '0);
  assign result       = out_result;

endmodule

// ----- src/gcd_ctrl.sv -----
`timescale 1ns / 1ps

module gcd_ctrl import gcd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  gcd_sts_t sts,
  output gcd_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_RDIV   = 9'b000000100,
    S_RNEXT  = 9'b000001000,
    S_QDIV   = 9'b000010000,
    S_QNEXT  = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_MNEXT  = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_next;
  logic            out_valid_next;
  logic            out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mode && sts.zero_op) begin
          cmd.res_zero = 1'b1;
          state_next   = S_FINISH;
        end else if (sts.b_zero && !sts.mode) begin
          cmd.res_gcd = 1'b1;
          state_next  = S_FINISH;
        end else if (sts.b_zero) begin
          cmd.start_qdiv = 1'b1;
          cnt_next       = '0;
          state_next     = S_QDIV;
        end else begin
          cmd.start_rdiv = 1'b1;
          cnt_next       = '0;
          state_next     = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LastStep) begin
          state_next = S_RNEXT;
        end
      end
      S_RNEXT: begin
        cmd.rdiv_done = 1'b1;
        state_next    = S_CHECK;
      end
      S_QDIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LastStep) begin
          state_next = S_QNEXT;
        end
      end
      S_QNEXT: begin
        cmd.qdiv_done = 1'b1;
        cnt_next      = '0;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LastStep) begin
          state_next = S_MNEXT;
        end
      end
      S_MNEXT: begin
        cmd.res_lcm = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // A finished result never overwrites one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register overwritten before transfer");

  // Division never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDIV || state == S_QDIV) |-> !sts.dvs_zero)
    else $error("division started with zero divisor");

  // A remainder pass ends after exactly one full sweep of the counter.
  a_rdiv_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDIV && cnt == LastStep) |=> (state == S_RNEXT))
    else $error("remainder pass did not end on the last step");

  // A waiting result holds until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !out_free) |=> (state == S_FINISH && out_valid))
    else $error("finished item left before the output register was free");

endmodule

// ----- src/gcd_lcm_unit.sv -----
`timescale 1ns / 1ps
// In GCD mode the result follows k Euclid remainder steps, where k is at most 91 for
// operand magnitudes up to 2^63; each step is one restoring division pass. LCM mode adds
// a quotient pass and a shift-add multiply; an LCM with a zero operand skips all of these.
// One item is in work at a time; input ready rises together with output valid, so the next
// input transfer can follow while that result waits. Reset (synchronous, active high)
// idles the controller and drops output valid.

module gcd_lcm_unit import gcd_pkg::*; (
  input logic      clk,
  input logic      rst,
  gcd_req_if.sink  req,
  gcd_rsp_if.source rsp
);

  gcd_cmd_t cmd;
  gcd_sts_t sts;

  gcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gcd_dp u_dp (
    .clk      (clk),
    .mode_in  (req.mode),
    .left_in  (req.left_operand),
    .right_in (req.right_operand),
    .cmd      (cmd),
    .sts      (sts),
    .result   (rsp.result)
  );

endmodule
